/* design/scalar_kalman_filter_defines.svh */
`ifndef SCALAR_KALMAN_FILTER_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_DEFINES_SVH

// Same-cycle implication on clk, quiet during reset
`define SKF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk, quiet during reset
`define SKF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/skf_pkg.sv */
`timescale 1ns / 1ps

package skf_pkg;

  // Filter geometry
  localparam int CHANNELS      = 4;
  localparam int FRACTION_BITS = 16;
  localparam int IDX_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths
  localparam int CH_W     = 2;
  localparam int SAMPLE_W = 12;
  localparam int EST_W    = 12;
  localparam int MEAN_W   = 32;
  localparam int VAR_W    = 32;
  localparam int DRIFT_W  = 29;
  localparam int NOISE_W  = 25;

  // Datapath widths
  localparam int Z_W    = SAMPLE_W + FRACTION_BITS;
  localparam int Y_W    = ((Z_W + 1 > MEAN_W) ? Z_W + 1 : MEAN_W) + 1;
  localparam int K_W    = FRACTION_BITS;
  localparam int DIV_W  = VAR_W + 1;
  localparam int PROD_W = Y_W + K_W + 1;
  localparam int SUM_W  = Y_W + 2;
  localparam int PM_W   = VAR_W + K_W + 1;
  localparam int CNT_W  = $clog2(K_W);
  localparam int HI_W   = MEAN_W - FRACTION_BITS;

  // Config port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Reset values
  localparam logic [63:0] VAR_RESET_W64  = 64'd100 << FRACTION_BITS;
  localparam logic [63:0] QVAR_RESET_W64 = 64'd1 << FRACTION_BITS;
  localparam logic [63:0] RVAR_RESET_W64 = 64'd16 << FRACTION_BITS;
  localparam logic [VAR_W-1:0]   VAR_RESET  = VAR_RESET_W64[VAR_W-1:0];
  localparam logic [NOISE_W-1:0] QVAR_RESET = QVAR_RESET_W64[NOISE_W-1:0];
  localparam logic [NOISE_W-1:0] RVAR_RESET = RVAR_RESET_W64[NOISE_W-1:0];

  localparam logic [K_W:0]       ONE_FX  = {1'b1, {K_W{1'b0}}};
  localparam logic [MEAN_W-1:0]  HALF_FX = MEAN_W'(1) << (FRACTION_BITS - 1);
  localparam logic [EST_W-1:0]   EST_MAX = '1;

  // Register map (word index)
  typedef enum logic [1:0] {
    REG_DRIFT         = 2'd0,
    REG_PROCESS_NOISE = 2'd1,
    REG_SENSOR_NOISE  = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_DIV,
    ST_MUL,
    ST_POST,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
  } skf_in_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel_out;
    logic [EST_W-1:0] estimate;
    logic [VAR_W-1:0] estimate_variance;
  } skf_out_t;

  // Channel number folded onto the store depth
  function automatic logic [IDX_W-1:0] chan_index(input logic [CH_W-1:0] ch);
    int v;
    v = int'(ch);
    for (int i = 0; i < (1 << CH_W); i++) begin
      if (v >= CHANNELS) begin
        v = v - CHANNELS;
      end
    end
    return IDX_W'(v);
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [MEAN_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-MEAN_W:0] top;
    top = v[SUM_W-1:MEAN_W-1];
    if (top == '0 || top == '1) begin
      return v[MEAN_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(MEAN_W-1){1'b0}}};
    end else begin
      return {1'b0, {(MEAN_W-1){1'b1}}};
    end
  endfunction

endpackage

/* design/scalar_kalman_filter.sv */
`timescale 1ns / 1ps
// Scalar Kalman filter, one state pair (mean, variance) per sensor channel.
// Input channel: item_valid / item_stall with item = {channel, sample}. A word
//   is taken when item_valid is high and item_stall low; item_stall is high
//   while a sample is being worked on, so one sample is in flight at a time.
// Output channel: result_valid / result_stall with result = {channel_out,
//   estimate, estimate_variance}, held in an output register until taken.
// Config: APB-style, drift at 0x0, process variance at 0x4, sensor variance
//   at 0x8. Writes belong to idle periods only.
// Steps: the state RAM read rides on the accept edge; then come predict, the
//   gain divider (one quotient bit per cycle), the two multiplies (side by
//   side), correction and result formatting.
// Reset: config goes to drift 0, Q 1.0, R 16.0; per-channel valid bits clear
//   so every channel reads mean 0 and variance 100.0 until first written.
// A stalled result holds the block in its last step; no new sample is taken
//   until the result register is free.
`include "scalar_kalman_filter_defines.svh"

module scalar_kalman_filter (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  skf_pkg::skf_in_t        item,
  output logic                    result_valid,
  input  logic                    result_stall,
  output skf_pkg::skf_out_t       result,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [skf_pkg::ADDR_W-1:0] paddr,
  input  logic [skf_pkg::DATA_W-1:0] pwdata,
  output logic [skf_pkg::DATA_W-1:0] prdata,
  output logic                    pready
);

  import skf_pkg::*;

  state_t state, state_next;

  logic item_accept;
  logic mem_we;
  logic out_load;
  logic cfg_write;

  // Config registers
  logic [DRIFT_W-1:0] drift;
  logic [NOISE_W-1:0] proc_var;
  logic [NOISE_W-1:0] sens_var;

  // Latched item
  logic [CH_W-1:0]     ch_reg;
  logic [SAMPLE_W-1:0] sample_reg;
  logic [IDX_W-1:0]    idx_reg;

  // State RAMs
  logic [MEAN_W-1:0]   mean_mem [CHANNELS];
  logic [VAR_W-1:0]    var_mem  [CHANNELS];
  logic [CHANNELS-1:0] mem_valid;
  logic [MEAN_W-1:0]   mean_rd;
  logic [VAR_W-1:0]    var_rd;
  logic                rd_valid;

  // Datapath registers
  logic signed [MEAN_W-1:0] x_reg;
  logic [VAR_W-1:0]         p_reg;
  logic [DIV_W-1:0]         div_d;
  logic [DIV_W-1:0]         rem;
  logic [K_W-1:0]           quo;
  logic [CNT_W-1:0]         cnt;
  logic signed [Y_W-1:0]    y_reg;
  logic signed [PROD_W-1:0] prod;
  logic [PM_W-1:0]          pm;
  logic signed [MEAN_W-1:0] x_post;
  logic [VAR_W-1:0]         var_post;

  // Predict-step wires
  logic signed [MEAN_W-1:0]  mean_cur;
  logic [VAR_W-1:0]          var_cur;
  logic signed [DRIFT_W-1:0] drift_s;
  logic signed [SUM_W-1:0]   mean_sum;
  logic [DIV_W-1:0]          p_sum;
  logic [VAR_W-1:0]          p_sat;
  logic [NOISE_W-1:0]        r_eff;

  // Divider wires
  logic [DIV_W:0] rem_sh;
  logic [DIV_W:0] rem_diff;

  // Update wires
  logic signed [Z_W:0]                   z_ext;
  logic [K_W:0]                          one_minus_k;
  logic signed [PROD_W-FRACTION_BITS-1:0] prod_fl;
  logic signed [SUM_W-1:0]               x_new_sum;

  // Output formatting wires
  logic [MEAN_W-1:0]        rounded;
  logic [HI_W+EST_W-1:0]    hi_ext;
  logic [EST_W-1:0]         est;

  assign item_accept = item_valid && !item_stall;
  assign cfg_write   = psel && penable && pwrite;
  assign pready      = 1'b1;

  // Config write
  always_ff @(posedge clk) begin
    if (rst) begin
      drift    <= '0;
      proc_var <= QVAR_RESET;
      sens_var <= RVAR_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_DRIFT:         drift    <= pwdata[DRIFT_W-1:0];
        REG_PROCESS_NOISE: proc_var <= pwdata[NOISE_W-1:0];
        REG_SENSOR_NOISE:  sens_var <= pwdata[NOISE_W-1:0];
        default: ;
      endcase
    end
  end

  // Config read
  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_DRIFT:         prdata = DATA_W'(drift);
      REG_PROCESS_NOISE: prdata = DATA_W'(proc_var);
      REG_SENSOR_NOISE:  prdata = DATA_W'(sens_var);
      default:           prdata = '0;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (item_valid) state_next = ST_PRED;
      ST_PRED: state_next = ST_DIV;
      ST_DIV:  if (cnt == CNT_W'(K_W - 1)) state_next = ST_MUL;
      ST_MUL:  state_next = ST_POST;
      ST_POST: state_next = ST_OUT;
      ST_OUT:  if (!result_valid || !result_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    item_stall = 1'b1;
    mem_we     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: item_stall = 1'b0;
      ST_OUT: begin
        mem_we   = 1'b1;
        out_load = !result_valid || !result_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item latch
  always_ff @(posedge clk) begin
    if (item_accept) begin
      ch_reg     <= item.channel;
      sample_reg <= item.sample;
      idx_reg    <= chan_index(item.channel);
    end
  end

  // State RAMs: read on accept, write back in the result step.
  // One sample in flight, so the write always lands before the next read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mean_mem[idx_reg] <= x_post;
      var_mem[idx_reg]  <= var_post;
    end
    if (item_accept) begin
      mean_rd <= mean_mem[chan_index(item.channel)];
      var_rd  <= var_mem[chan_index(item.channel)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (mem_we) begin
        mem_valid[idx_reg] <= 1'b1;
      end
      if (item_accept) begin
        rd_valid <= mem_valid[chan_index(item.channel)];
      end
    end
  end

  // Predict
  always_comb begin
    mean_cur = rd_valid ? mean_rd : '0;
    var_cur  = rd_valid ? var_rd : VAR_RESET;
    drift_s  = drift;
    mean_sum = SUM_W'(mean_cur) + SUM_W'(drift_s);
    p_sum    = DIV_W'(var_cur) + DIV_W'(proc_var);
    p_sat    = p_sum[DIV_W-1] ? '1 : p_sum[VAR_W-1:0];
    r_eff    = (sens_var == '0) ? NOISE_W'(1) : sens_var;
  end

  // Restoring divide step
  always_comb begin
    rem_sh   = {rem, 1'b0};
    rem_diff = rem_sh - {1'b0, div_d};
  end

  // Residual and gain complement
  always_comb begin
    z_ext       = {1'b0, sample_reg, {FRACTION_BITS{1'b0}}};
    one_minus_k = ONE_FX - {1'b0, quo};
    prod_fl     = prod[PROD_W-1:FRACTION_BITS];
    x_new_sum   = SUM_W'(x_reg) + SUM_W'(prod_fl);
  end

  // Datapath sequencing
  always_ff @(posedge clk) begin
    unique case (state)
      ST_PRED: begin
        x_reg <= sat32(mean_sum);
        p_reg <= p_sat;
        div_d <= DIV_W'(p_sat) + DIV_W'(r_eff);
        rem   <= DIV_W'(p_sat);
        quo   <= '0;
        cnt   <= '0;
      end
      ST_DIV: begin
        if (!rem_diff[DIV_W]) begin
          rem <= rem_diff[DIV_W-1:0];
          quo <= {quo[K_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DIV_W-1:0];
          quo <= {quo[K_W-2:0], 1'b0};
        end
        cnt   <= cnt + CNT_W'(1);
        y_reg <= Y_W'(z_ext) - Y_W'(x_reg);
      end
      ST_MUL: begin
        prod <= PROD_W'(signed'({1'b0, quo})) * PROD_W'(y_reg);
        pm   <= PM_W'(one_minus_k) * PM_W'(p_reg);
      end
      ST_POST: begin
        x_post   <= sat32(x_new_sum);
        var_post <= pm[FRACTION_BITS +: VAR_W];
      end
      default: ;
    endcase
  end

  // Round half up, clamp to converter range
  always_comb begin
    rounded = {1'b0, x_post[MEAN_W-2:0]} + HALF_FX;
    hi_ext  = (HI_W + EST_W)'(rounded[MEAN_W-1:FRACTION_BITS]);
    if (x_post[MEAN_W-1]) begin
      est = '0;
    end else if (hi_ext > (HI_W + EST_W)'(EST_MAX)) begin
      est = EST_MAX;
    end else begin
      est = hi_ext[EST_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.channel_out       <= ch_reg;
      result.estimate          <= est;
      result.estimate_variance <= var_post;
    end
  end

  // Checks
  `SKF_ASSERT_NOW(a_div_rem_below_divisor, state == ST_DIV, rem < div_d, "divider remainder not below divisor")
  `SKF_ASSERT_NOW(a_var_not_grown, state == ST_OUT, var_post <= p_reg, "posterior variance above prior")
  `SKF_ASSERT_NEXT(a_accept_to_predict, item_accept, state == ST_PRED, "accepted word did not start predict")
  `SKF_ASSERT_NEXT(a_stalled_result_holds, state == ST_OUT && result_valid && result_stall, state == ST_OUT, "left result step while output still stalled")

endmodule

/* tb/kalman_result_checker.sv */
`timescale 1ns / 1ps

// Watches the sample, result and register ports of the filter. It keeps its
// own per-channel mean and variance, predicts the result word of every
// accepted sample and compares it with the words that come out.
module kalman_result_checker
  import skf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  skf_in_t           item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  skf_out_t          result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                fails,
  output int                pending
);

  localparam longint MEAN_MAX = 64'sh7FFF_FFFF;
  localparam longint MEAN_MIN = -MEAN_MAX - 1;

  // Filter state and register copies
  logic signed [MEAN_W-1:0]  mean_est [CHANNELS];
  logic        [VAR_W-1:0]   var_est  [CHANNELS];
  logic signed [DRIFT_W-1:0] drift_cfg;
  logic        [NOISE_W-1:0] q_cfg;
  logic        [NOISE_W-1:0] r_cfg;

  // Result words still owed by the block, oldest first
  skf_out_t expected_words[$];

  function automatic longint clamp_mean(input longint v);
    if (v > MEAN_MAX) return MEAN_MAX;
    if (v < MEAN_MIN) return MEAN_MIN;
    return v;
  endfunction

  // Predict and update one channel; returns the word the block should report
  function automatic skf_out_t kalman_update(input skf_in_t w);
    int                idx;
    longint            x;
    longint            y;
    longint            prod;
    longint            est;
    longint unsigned   p;
    longint unsigned   r;
    longint unsigned   k;
    longint unsigned   p_post;
    skf_out_t          word;
    idx = int'(w.channel) % CHANNELS;
    // predict
    x = clamp_mean(longint'(mean_est[idx]) + longint'(drift_cfg));
    p = var_est[idx];
    p = p + q_cfg;
    if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
    // update; zero R acts as one LSB
    r = (r_cfg == '0) ? 64'd1 : 64'(r_cfg);
    k = (p << FRACTION_BITS) / (p + r);
    y = (longint'(w.sample) <<< FRACTION_BITS) - x;
    prod = longint'(k) * y;
    x = clamp_mean(x + (prod >>> FRACTION_BITS));
    p_post = (((64'd1 << FRACTION_BITS) - k) * p) >> FRACTION_BITS;
    mean_est[idx] = MEAN_W'(x);
    var_est[idx]  = VAR_W'(p_post);
    // round half up on the positive side, clamp to converter range
    if (x < 0) begin
      est = 0;
    end else begin
      est = (x + (64'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
      if (est > longint'(EST_MAX)) est = longint'(EST_MAX);
    end
    word.channel_out       = w.channel;
    word.estimate          = EST_W'(est);
    word.estimate_variance = VAR_W'(p_post);
    return word;
  endfunction

  always @(posedge clk) begin
    skf_out_t want;
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        mean_est[c] = '0;
        var_est[c]  = VAR_RESET;
      end
      drift_cfg = '0;
      q_cfg     = QVAR_RESET;
      r_cfg     = RVAR_RESET;
      expected_words.delete();
      fails = 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[ADDR_W-1:2]))
          REG_DRIFT:         drift_cfg = pwdata[DRIFT_W-1:0];
          REG_PROCESS_NOISE: q_cfg     = pwdata[NOISE_W-1:0];
          REG_SENSOR_NOISE:  r_cfg     = pwdata[NOISE_W-1:0];
          default: ;
        endcase
      end
      // outgoing word against the oldest expectation, before any new push
      if (result_valid && !result_stall) begin
        if (expected_words.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word, expected none, got %h", $time, result);
        end else begin
          want = expected_words.pop_front();
          if (result.channel_out !== want.channel_out) begin
            fails++;
            $display("%0t: channel_out expected %0d, got %0d", $time,
                     want.channel_out, result.channel_out);
          end
          if (result.estimate !== want.estimate) begin
            fails++;
            $display("%0t: estimate expected %0d, got %0d", $time,
                     want.estimate, result.estimate);
          end
          if (result.estimate_variance !== want.estimate_variance) begin
            fails++;
            $display("%0t: estimate_variance expected %h, got %h", $time,
                     want.estimate_variance, result.estimate_variance);
          end
        end
      end
      // incoming sample word
      if (item_valid && !item_stall) begin
        expected_words.push_back(kalman_update(item));
      end
    end
    pending = expected_words.size();
  end

endmodule

/* tb/tb_scalar_kalman_filter.sv */
`timescale 1ns / 1ps

module tb_scalar_kalman_filter;
  import skf_pkg::*;

  localparam int                  SETTLE_CYCLES = 30;
  localparam int                  PHASES        = 10;
  localparam int                  PHASE_WORDS   = 155;
  localparam logic signed [DRIFT_W-1:0] DRIFT_MAX = 29'sh0FFF_FFFF;
  localparam logic signed [DRIFT_W-1:0] DRIFT_MIN = 29'sh1000_0000;
  localparam logic [NOISE_W-1:0]  NOISE_MAX     = 25'h100_0000;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  skf_in_t           item;
  logic              result_valid;
  logic              result_stall;
  skf_out_t          result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int fail_count;
  int words_pending;
  int burst_left;

  scalar_kalman_filter uut (.*);

  kalman_result_checker result_check (
    .*,
    .fails   (fail_count),
    .pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6ms;
    $display("scalar_kalman_filter test failed");
    $finish;
  end

  // Register write: setup cycle, then access until pready
  task automatic cfg_write(input reg_index_t idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_filter_config(input logic signed [DRIFT_W-1:0] drift,
                                    input logic [NOISE_W-1:0] q,
                                    input logic [NOISE_W-1:0] r);
    cfg_write(REG_DRIFT, DATA_W'(drift));
    cfg_write(REG_PROCESS_NOISE, DATA_W'(q));
    cfg_write(REG_SENSOR_NOISE, DATA_W'(r));
  endtask

  // Offer one sample word; bursts of random length with random gaps between
  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item.channel <= ch;
    item.sample  <= s;
    item_valid   <= 1'b1;
    do @(posedge clk); while (item_stall);
  endtask

  // Hold off until every owed word has come out, then let the block settle
  task automatic wait_idle();
    item_valid <= 1'b0;
    @(negedge clk);
    while (words_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: own stall pattern, plus one long hold-off
  initial begin
    int  seg;
    int  mode;
    int  spent;
    bit  long_done;
    result_stall <= 1'b0;
    spent     = 0;
    long_done = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (!long_done && spent > 3000) begin
        result_stall <= 1'b1;
        repeat (500) @(posedge clk);
        long_done = 1'b1;
        spent += 500;
      end else begin
        seg  = $urandom_range(10, 150);
        mode = $urandom_range(0, 3);
        repeat (seg) begin
          case (mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 3) == 0);
            2:       result_stall <= ($urandom_range(0, 3) != 0);
            default: result_stall <= ~result_stall;
          endcase
          @(posedge clk);
        end
        spent += seg;
      end
    end
  end

  // Stimulus
  initial begin
    logic signed [DRIFT_W-1:0] drift;
    logic [NOISE_W-1:0]        q;
    logic [NOISE_W-1:0]        r;
    logic [SAMPLE_W-1:0]       s;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every channel at both ends of the range, alternating bits
    for (int c = 0; c < (1 << CH_W); c++) send_sample(CH_W'(c), '0);
    for (int c = 0; c < (1 << CH_W); c++) send_sample(CH_W'(c), '1);
    send_sample(2'd0, 12'hAAA);
    send_sample(2'd1, 12'h555);
    send_sample(2'd2, 12'h555);
    send_sample(2'd3, 12'hAAA);

    // Directed: zero sensor variance with the largest process variance
    wait_idle();
    load_filter_config(DRIFT_MAX, NOISE_MAX, '0);
    for (int c = 0; c < (1 << CH_W); c++) send_sample(CH_W'(c), 12'hFFF - 12'(c));
    send_sample(2'd0, 12'd0);
    send_sample(2'd1, 12'd2048);

    // Random phases; the first four pin the register extremes
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin drift = DRIFT_MAX; q = '0;        r = NOISE_MAX; end
        1: begin drift = DRIFT_MIN; q = '0;        r = NOISE_MAX; end
        2: begin drift = '0;        q = NOISE_MAX; r = '0;        end
        3: begin drift = '0;        q = '0;        r = 25'd1;     end
        default: begin
          case ($urandom_range(0, 2))
            0:       drift = DRIFT_W'($urandom());
            1:       drift = DRIFT_W'($urandom_range(0, 1 << 19)) - DRIFT_W'(1 << 18);
            default: drift = '0;
          endcase
          q = NOISE_W'($urandom_range(0, 1 << 24));
          r = ($urandom_range(0, 7) == 0) ? '0 : NOISE_W'($urandom_range(1, 1 << 24));
        end
      endcase
      // sender pauses here until every owed word has arrived
      wait_idle();
      load_filter_config(drift, q, r);
      repeat (PHASE_WORDS) begin
        case ($urandom_range(0, 9))
          0:       s = '0;
          1:       s = '1;
          default: s = SAMPLE_W'($urandom());
        endcase
        send_sample(CH_W'($urandom_range(0, (1 << CH_W) - 1)), s);
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("scalar_kalman_filter test passed");
    end else begin
      $display("scalar_kalman_filter test failed");
    end
    $finish;
  end

endmodule
